// ----- sv/q4jd_pkg.sv -----
// ----------------------------------------------------------------------------
// q4jd_pkg: shared types and helpers for the Q4 Jacobian pipeline
// Item layouts between the pipeline sections and fixed-point helpers.
// ----------------------------------------------------------------------------
package q4jd_pkg;

  localparam int COORD_WIDTH = 32;
  // Coordinates are sign-extended from bit CW_EFF-1.
  localparam int CW_EFF = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

  // Quotient bits kept by the divider; larger quotients saturate anyway.
  localparam int QBITS = 33;

  localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [15:0]       xi;
    logic [15:0]       eta;
    logic [3:0][31:0]  cx;
    logic [3:0][31:0]  cy;
  } item_t;

  // j[0]=J00, j[1]=J01, j[2]=J10, j[3]=J11
  typedef struct packed {
    logic [3:0][31:0] j;
    logic [3:0][17:0] dxi;
    logic [3:0][17:0] deta;
  } jac_t;

  // lanes 0..3: d/dx of nodes 0..3, lanes 4..7: d/dy of nodes 0..3
  typedef struct packed {
    logic [63:0]      det;
    logic [63:0]      ud;
    logic             singular;
    logic             geo;
    logic [7:0][63:0] un;
    logic [7:0]       neg;
  } dvin_t;

  typedef struct packed {
    logic [63:0]      det;
    logic [63:0]      ud;
    logic             singular;
    logic             geo;
    logic [7:0][63:0] rem;
    logic [7:0][32:0] q;
    logic [7:0]       ovf;
    logic [7:0]       neg;
  } dvout_t;

  function automatic logic signed [31:0] coord_sext(logic [31:0] v);
    logic [31:0] m;
    m = v << (32 - CW_EFF);
    return $signed(m) >>> (32 - CW_EFF);
  endfunction

  // Saturate a 36-bit signed value to 32 bits.
  function automatic logic [31:0] sat_q16(logic [35:0] v);
    logic [31:0] r;
    if (!v[35] && (v[34:31] != 4'h0)) begin
      r = Q16_MAX;
    end else if (v[35] && (v[34:31] != 4'hF)) begin
      r = Q16_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/q4jd_jac.sv -----
// ----------------------------------------------------------------------------
// q4jd_jac: natural derivatives and Jacobian entries
// Two stages: shape-derivative products, then sums rounded to Q16.16.
// ----------------------------------------------------------------------------
module q4jd_jac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  q4jd_pkg::item_t    up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output q4jd_pkg::jac_t     dn_data
);

  logic v1_r, v2_r, adv1, adv2;
  logic signed [17:0] dxi_nxt [4];
  logic signed [17:0] deta_nxt [4];
  logic signed [17:0] dxi_r [4];
  logic signed [17:0] deta_r [4];
  logic signed [31:0] cx [4];
  logic signed [31:0] cy [4];
  logic signed [49:0] p_nxt [4][4];
  logic signed [49:0] p_r [4][4];
  logic signed [51:0] s [4];
  logic signed [51:0] t [4];
  q4jd_pkg::jac_t jd_nxt, jd_r;

  assign adv2     = !v2_r || dn_ready;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;

  always_comb begin
    logic signed [17:0] xi18, eta18;
    xi18  = 18'($signed(up_data.xi));
    eta18 = 18'($signed(up_data.eta));
    dxi_nxt[0]  = eta18 - q4jd_pkg::ONE_Q14;
    dxi_nxt[1]  = q4jd_pkg::ONE_Q14 - eta18;
    dxi_nxt[2]  = q4jd_pkg::ONE_Q14 + eta18;
    dxi_nxt[3]  = -q4jd_pkg::ONE_Q14 - eta18;
    deta_nxt[0] = xi18 - q4jd_pkg::ONE_Q14;
    deta_nxt[1] = -q4jd_pkg::ONE_Q14 - xi18;
    deta_nxt[2] = q4jd_pkg::ONE_Q14 + xi18;
    deta_nxt[3] = q4jd_pkg::ONE_Q14 - xi18;
    for (int k = 0; k < 4; k++) begin
      cx[k] = q4jd_pkg::coord_sext(up_data.cx[k]);
      cy[k] = q4jd_pkg::coord_sext(up_data.cy[k]);
      p_nxt[0][k] = 50'(dxi_nxt[k])  * 50'(cx[k]);
      p_nxt[1][k] = 50'(dxi_nxt[k])  * 50'(cy[k]);
      p_nxt[2][k] = 50'(deta_nxt[k]) * 50'(cx[k]);
      p_nxt[3][k] = 50'(deta_nxt[k]) * 50'(cy[k]);
    end
  end

  // sum, add one half, floor to Q16.16, saturate
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      s[r] = 52'(p_r[r][0]) + 52'(p_r[r][1]) + 52'(p_r[r][2]) + 52'(p_r[r][3]);
      t[r] = s[r] + 52'sd32768;
      jd_nxt.j[r]    = q4jd_pkg::sat_q16(t[r][51:16]);
      jd_nxt.dxi[r]  = dxi_r[r];
      jd_nxt.deta[r] = deta_r[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      dxi_r  <= dxi_nxt;
      deta_r <= deta_nxt;
      p_r    <= p_nxt;
    end
    if (adv2 && v1_r) begin
      jd_r <= jd_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = jd_r;

endmodule

// ----- sv/q4jd_det.sv -----
// ----------------------------------------------------------------------------
// q4jd_det: determinant, cofactor numerators and singularity test
// Two stages: products of the Jacobian entries, then differences and magnitudes.
// ----------------------------------------------------------------------------
module q4jd_det (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [62:0]        tol,
  input  logic               up_valid,
  output logic               up_ready,
  input  q4jd_pkg::jac_t     up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output q4jd_pkg::dvin_t    dn_data
);

  logic v3_r, v4_r, adv3, adv4;
  logic signed [63:0] a_nxt, b_nxt, a_r, b_r;
  logic signed [49:0] nxa_nxt [4];
  logic signed [49:0] nxb_nxt [4];
  logic signed [49:0] nya_nxt [4];
  logic signed [49:0] nyb_nxt [4];
  logic signed [49:0] nxa_r [4];
  logic signed [49:0] nxb_r [4];
  logic signed [49:0] nya_r [4];
  logic signed [49:0] nyb_r [4];
  q4jd_pkg::dvin_t dv_nxt, dv_r;

  assign adv4     = !v4_r || dn_ready;
  assign adv3     = !v3_r || adv4;
  assign up_ready = adv3;

  always_comb begin
    logic signed [31:0] j00, j01, j10, j11;
    j00 = $signed(up_data.j[0]);
    j01 = $signed(up_data.j[1]);
    j10 = $signed(up_data.j[2]);
    j11 = $signed(up_data.j[3]);
    a_nxt = 64'(j00) * 64'(j11);
    b_nxt = 64'(j01) * 64'(j10);
    for (int k = 0; k < 4; k++) begin
      nxa_nxt[k] = 50'(j11) * 50'($signed(up_data.dxi[k]));
      nxb_nxt[k] = 50'(j01) * 50'($signed(up_data.deta[k]));
      nya_nxt[k] = 50'(j00) * 50'($signed(up_data.deta[k]));
      nyb_nxt[k] = 50'(j10) * 50'($signed(up_data.dxi[k]));
    end
  end

  // numerator magnitude stays below 2^48, so the Q16 shift fits 64 bits
  always_comb begin
    logic [63:0] det;
    logic [50:0] num [8];
    logic [50:0] an;
    det = 64'(a_r - b_r);
    for (int k = 0; k < 4; k++) begin
      num[k]     = 51'(nxa_r[k]) - 51'(nxb_r[k]);
      num[4 + k] = 51'(nya_r[k]) - 51'(nyb_r[k]);
    end
    dv_nxt.det      = det;
    dv_nxt.ud       = det[63] ? (64'd0 - det) : det;
    dv_nxt.singular = (det == 64'd0) || (dv_nxt.ud < {1'b0, tol});
    dv_nxt.geo      = !dv_nxt.singular && ($signed(det) > $signed({1'b0, tol}));
    for (int l = 0; l < 8; l++) begin
      an = num[l][50] ? (51'd0 - num[l]) : num[l];
      dv_nxt.un[l]  = {an[47:0], 16'h0000};
      dv_nxt.neg[l] = num[l][50] ^ det[63];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv3) v3_r <= up_valid;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && up_valid) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      nxa_r <= nxa_nxt;
      nxb_r <= nxb_nxt;
      nya_r <= nya_nxt;
      nyb_r <= nyb_nxt;
    end
    if (adv4 && v3_r) begin
      dv_r <= dv_nxt;
    end
  end

  assign dn_valid = v4_r;
  assign dn_data  = dv_r;

endmodule

// ----- sv/q4jd_div.sv -----
// ----------------------------------------------------------------------------
// q4jd_div: eight-lane pipelined restoring divider
// One setup stage with overflow test, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module q4jd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  q4jd_pkg::dvin_t    up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output q4jd_pkg::dvout_t   dn_data
);

  localparam int QB = q4jd_pkg::QBITS;

  typedef struct packed {
    logic [63:0]        det;
    logic [63:0]        ud;
    logic               singular;
    logic               geo;
    logic [7:0][63:0]   rem;
    logic [7:0][QB-1:0] low;
    logic [7:0][QB-1:0] q;
    logic [7:0]         ovf;
    logic [7:0]         neg;
  } stage_t;

  stage_t st_nxt [QB+1];
  stage_t st_r   [QB+1];
  logic   v_r    [QB+1];
  logic   v_in   [QB+1];
  logic   adv    [QB+1];

  for (genvar g = 0; g <= QB; g++) begin : g_st
    if (g == QB) begin : g_last
      assign adv[g] = !v_r[g] || dn_ready;
    end else begin : g_mid
      assign adv[g] = !v_r[g] || adv[g+1];
    end

    if (g == 0) begin : g_setup
      assign v_in[g] = up_valid;
      // quotient of 2^QB or more saturates in any case
      always_comb begin
        st_nxt[g].det      = up_data.det;
        st_nxt[g].ud       = up_data.ud;
        st_nxt[g].singular = up_data.singular;
        st_nxt[g].geo      = up_data.geo;
        st_nxt[g].neg      = up_data.neg;
        for (int l = 0; l < 8; l++) begin
          st_nxt[g].rem[l] = 64'(up_data.un[l][63:QB]);
          st_nxt[g].low[l] = up_data.un[l][QB-1:0];
          st_nxt[g].q[l]   = '0;
          st_nxt[g].ovf[l] = 64'(up_data.un[l][63:QB]) >= up_data.ud;
        end
      end
    end else begin : g_iter
      assign v_in[g] = v_r[g-1];
      // partial remainder stays below the divisor, so its top bit is clear
      always_comb begin
        logic [63:0] r2;
        st_nxt[g] = st_r[g-1];
        for (int l = 0; l < 8; l++) begin
          r2 = {st_r[g-1].rem[l][62:0], st_r[g-1].low[l][QB-1]};
          if (r2 >= st_r[g-1].ud) begin
            st_nxt[g].rem[l] = r2 - st_r[g-1].ud;
            st_nxt[g].q[l]   = {st_r[g-1].q[l][QB-2:0], 1'b1};
          end else begin
            st_nxt[g].rem[l] = r2;
            st_nxt[g].q[l]   = {st_r[g-1].q[l][QB-2:0], 1'b0};
          end
          st_nxt[g].low[l] = {st_r[g-1].low[l][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv[g]) begin
        v_r[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[g] && v_in[g]) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_r[QB];

  always_comb begin
    dn_data.det      = st_r[QB].det;
    dn_data.ud       = st_r[QB].ud;
    dn_data.singular = st_r[QB].singular;
    dn_data.geo      = st_r[QB].geo;
    dn_data.rem      = st_r[QB].rem;
    dn_data.q        = st_r[QB].q;
    dn_data.ovf      = st_r[QB].ovf;
    dn_data.neg      = st_r[QB].neg;
  end

endmodule

// ----- sv/q4_jacobian_global_derivs.sv -----
// ----------------------------------------------------------------------------
// q4_jacobian_global_derivs: Q4 element Jacobian and global shape derivatives
// Streams natural points plus corner coordinates in, B-matrix entries out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries one request per item: xi, eta (Q2.14) and the four corner
//         coordinates (Q16.16). out_* returns one result per request, in order:
//         dN/dx and dN/dy for each node, the Q32.32 determinant, and in tuser
//         the singular status and the geometry_ok flag.
//   cfg_we/cfg_wdata load det_tolerance (Q32.32); write it only while idle.
// Depth: 2 Jacobian stages, 2 determinant stages, 1 divider setup stage,
//   33 divider bit stages and one output register from input acceptance to
//   out_tvalid. Throughput: one request per cycle while out_tready is high;
//   the bit-per-stage restoring divider, eight lanes wide, sets the depth.
// Reset: rst_n (synchronous, low) empties the pipeline and sets the tolerance
//   to 1. No other state.
// Stall: each stage holds its item until the next stage has room, so a stalled
//   out_tready fills bubbles first and then backs up to in_tready; nothing is
//   dropped or repeated.
// ----------------------------------------------------------------------------
module q4_jacobian_global_derivs (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [62:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // xi[15:0], eta, node0_x, node0_y, node1_x, node1_y, node2_x, node2_y,
  // node3_x, node3_y
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // deriv_x_node0[31:0], deriv_x_node1..3, deriv_y_node0..3, det_jacobian
  output logic [319:0] out_tdata,
  // status[0], geometry_ok[1]
  output logic [1:0]   out_tuser
);

  logic [62:0]        tol_r;
  q4jd_pkg::item_t    item;
  q4jd_pkg::jac_t     jac_d;
  q4jd_pkg::dvin_t    dvi_d;
  q4jd_pkg::dvout_t   dvo_d;
  logic               jac_v, jac_rdy, dvi_v, dvi_rdy, dvo_v, dvo_rdy;
  logic               out_v_r, adv_o;
  logic [319:0]       data_nxt, data_r;
  logic [1:0]         user_nxt, user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 63'd1;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  always_comb begin
    item.xi  = in_tdata[15:0];
    item.eta = in_tdata[31:16];
    for (int k = 0; k < 4; k++) begin
      item.cx[k] = in_tdata[32 + 64*k +: 32];
      item.cy[k] = in_tdata[64 + 64*k +: 32];
    end
  end

  q4jd_jac u_jac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (item),
    .dn_valid (jac_v),
    .dn_ready (jac_rdy),
    .dn_data  (jac_d)
  );

  q4jd_det u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .tol      (tol_r),
    .up_valid (jac_v),
    .up_ready (jac_rdy),
    .up_data  (jac_d),
    .dn_valid (dvi_v),
    .dn_ready (dvi_rdy),
    .dn_data  (dvi_d)
  );

  q4jd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dvi_v),
    .up_ready (dvi_rdy),
    .up_data  (dvi_d),
    .dn_valid (dvo_v),
    .dn_ready (dvo_rdy),
    .dn_data  (dvo_d)
  );

  assign adv_o   = !out_v_r || out_tready;
  assign dvo_rdy = adv_o;

  // round to nearest (halves away from zero), apply sign, saturate; zero if singular
  always_comb begin
    logic        rnd;
    logic [33:0] qr;
    logic [31:0] d;
    for (int l = 0; l < 8; l++) begin
      rnd = {dvo_d.rem[l], 1'b0} >= {1'b0, dvo_d.ud};
      qr  = {1'b0, dvo_d.q[l]} + 34'(rnd);
      if (dvo_d.singular) begin
        d = 32'd0;
      end else if (dvo_d.neg[l]) begin
        d = (dvo_d.ovf[l] || (qr > 34'h8000_0000)) ? q4jd_pkg::Q16_MIN
                                                   : 32'(34'd0 - qr);
      end else begin
        d = (dvo_d.ovf[l] || (qr > 34'h7FFF_FFFF)) ? q4jd_pkg::Q16_MAX : qr[31:0];
      end
      data_nxt[32*l +: 32] = d;
    end
    data_nxt[319:256] = dvo_d.det;
    user_nxt          = {dvo_d.geo, dvo_d.singular};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv_o) begin
      out_v_r <= dvo_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && dvo_v) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// ----- test/tb_q4_jacobian_global_derivs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q4_jacobian_global_derivs: stream test of the Q4 Jacobian derivative block
// Random and directed natural points and quads are sent through the block
// under several det_tolerance settings. A bit-true predictor in the
// scoreboard computes each expected result, and the results are checked in
// order.
// ----------------------------------------------------------------------------
module tb_q4_jacobian_global_derivs;

  // Bit-true predictor and the in-order store of expected results
  class deriv_scoreboard;
    logic [62:0]  tol;
    logic [321:0] expected_q[$];   // {geometry_ok, status, tdata}
    int           errors;

    function new();
      tol    = 63'd1;
      errors = 0;
    endfunction

    function longint round_to_q16(longint v);
      longint          t;
      longint unsigned m;
      t = v + 32768;
      if (t >= 0) begin
        return t >>> 16;
      end
      m = 64'd0 - longint'(t);
      return -longint'((m + 64'd65535) >> 16);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // num * 2^16 / den, halves away from zero, saturated to Q16.16
    function longint quotient_q16(longint num, longint den);
      bit              neg;
      longint unsigned un, ud, q, r;
      neg = (num < 0) != (den < 0);
      un  = (num < 0) ? 64'd0 - num : num;
      ud  = (den < 0) ? 64'd0 - den : den;
      un  = un << 16;
      q   = un / ud;
      r   = un % ud;
      if (r >= ud - r) begin
        q++;
      end
      if (neg) begin
        if (q > 64'h8000_0000) begin
          return -64'sd2147483648;
        end
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) begin
        return 64'sd2147483647;
      end
      return longint'(q);
    endfunction

    function void note_request(logic [287:0] d);
      longint          xi, eta, cx[4], cy[4], dxi[4], deta[4];
      longint          s00, s01, s10, s11, j00, j01, j10, j11, det, dx, dy;
      longint unsigned mag;
      bit              singular, geo;
      logic [319:0]    res;
      xi  = longint'($signed(d[15:0]));
      eta = longint'($signed(d[31:16]));
      for (int k = 0; k < 4; k++) begin
        cx[k] = longint'($signed(d[32 + 64*k +: 32]));
        cy[k] = longint'($signed(d[64 + 64*k +: 32]));
      end
      dxi[0]  = -(16384 - eta);
      dxi[1]  = 16384 - eta;
      dxi[2]  = 16384 + eta;
      dxi[3]  = -(16384 + eta);
      deta[0] = -(16384 - xi);
      deta[1] = -(16384 + xi);
      deta[2] = 16384 + xi;
      deta[3] = 16384 - xi;
      s00 = 0; s01 = 0; s10 = 0; s11 = 0;
      for (int k = 0; k < 4; k++) begin
        s00 += dxi[k] * cx[k];
        s01 += dxi[k] * cy[k];
        s10 += deta[k] * cx[k];
        s11 += deta[k] * cy[k];
      end
      j00 = sat32(round_to_q16(s00));
      j01 = sat32(round_to_q16(s01));
      j10 = sat32(round_to_q16(s10));
      j11 = sat32(round_to_q16(s11));
      det = j00 * j11 - j01 * j10;
      mag = (det < 0) ? 64'd0 - det : det;
      // zero det is singular even with a zero tolerance
      singular = (det == 0) || (mag < {1'b0, tol});
      geo      = !singular && (det > longint'({1'b0, tol}));
      for (int k = 0; k < 4; k++) begin
        dx = 0;
        dy = 0;
        if (!singular) begin
          dx = quotient_q16(j11 * dxi[k] - j01 * deta[k], det);
          dy = quotient_q16(j00 * deta[k] - j10 * dxi[k], det);
        end
        res[32*k +: 32]       = dx[31:0];
        res[128 + 32*k +: 32] = dy[31:0];
      end
      res[319:256] = det;
      expected_q.push_back({geo, singular, res});
    endfunction

    function void check_result(logic [319:0] d, logic [1:0] u);
      logic [321:0] e;
      string        name;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result tdata=%h tuser=%b", d, u);
        return;
      end
      e = expected_q.pop_front();
      for (int f = 0; f < 8; f++) begin
        if (d[32*f +: 32] !== e[32*f +: 32]) begin
          errors++;
          name = (f < 4) ? $sformatf("deriv_x_node%0d", f) : $sformatf("deriv_y_node%0d", f - 4);
          if (errors <= 10) begin
            $display("%s: expected %h got %h", name, e[32*f +: 32], d[32*f +: 32]);
          end
        end
      end
      if (d[319:256] !== e[319:256]) begin
        errors++;
        if (errors <= 10) $display("det_jacobian: expected %h got %h", e[319:256], d[319:256]);
      end
      if (u[0] !== e[320]) begin
        errors++;
        if (errors <= 10) $display("status: expected %b got %b", e[320], u[0]);
      end
      if (u[1] !== e[321]) begin
        errors++;
        if (errors <= 10) $display("geometry_ok: expected %b got %b", e[321], u[1]);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [62:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;     // xi, eta, node0_x, node0_y, ... node3_y
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [319:0] out_tdata;         // deriv_x_node0..3, deriv_y_node0..3, det
  logic [1:0]   out_tuser;         // status, geometry_ok

  deriv_scoreboard sb = new();
  bit burst_mode;     // sender offers back to back
  int results_seen;

  always #5 clk = ~clk;

  q4_jacobian_global_derivs u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic logic [287:0] pack_point(logic [15:0] xi, logic [15:0] eta,
                                              int x[4], int y[4]);
    logic [287:0] d;
    d[15:0]  = xi;
    d[31:16] = eta;
    for (int k = 0; k < 4; k++) begin
      d[32 + 64*k +: 32] = x[k];
      d[64 + 64*k +: 32] = y[k];
    end
    return d;
  endfunction

  // Offer one request and hold it until accepted; tready sampled mid-cycle.
  task automatic send_request(logic [287:0] d);
    int gap;
    bit hs;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do begin
      @(negedge clk);
      hs = in_tready;
      @(posedge clk);
    end while (!hs);
    sb.note_request(d);
  endtask

  task automatic write_tolerance(logic [62:0] v);
    // drain: wait for the last result plus the pipeline depth
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tol = v;
  endtask

  // Mostly well-formed quads of random size and orientation, some pure noise.
  task automatic send_random(int n);
    int          x[4], y[4], sh, h, cxr, cyr, jit;
    logic [15:0] xi, eta;
    bit          cw;
    repeat (n) begin
      xi  = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      eta = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      if ($urandom_range(0, 6) == 0) begin
        for (int k = 0; k < 4; k++) begin
          x[k] = $urandom;
          y[k] = $urandom;
        end
      end else begin
        sh  = $urandom_range(0, 29);
        h   = $urandom_range(1, 1 << sh);
        cxr = $urandom_range(0, 1 << sh) - (1 << (sh - (sh > 0)));
        cyr = $urandom_range(0, 1 << sh) - (1 << (sh - (sh > 0)));
        cw  = ($urandom_range(0, 4) == 0);
        x[0] = cxr - h; y[0] = cyr - h;
        x[1] = cxr + h; y[1] = cyr - h;
        x[2] = cxr + h; y[2] = cyr + h;
        x[3] = cxr - h; y[3] = cyr + h;
        for (int k = 0; k < 4; k++) begin
          jit = $urandom_range(0, h / 2);
          x[k] += jit - h / 4;
          jit = $urandom_range(0, h / 2);
          y[k] += jit - h / 4;
          if (cw) y[k] = -y[k];    // clockwise: negative determinant
        end
      end
      send_request(pack_point(xi, eta, x, y));
    end
  endtask

  task automatic send_directed();
    int          x[4], y[4];
    logic [15:0] pts[8][2] = '{'{16'd0, 16'd0}, '{16'h4000, 16'h4000},
                               '{16'hC000, 16'hC000}, '{16'h4000, 16'hC000},
                               '{16'hC000, 16'h4000}, '{16'h8000, 16'h7FFF},
                               '{16'h7FFF, 16'h8000}, '{16'h2000, 16'hE000}};
    // unit square, all natural-point extremes and out-of-range points
    x = '{0, 65536, 65536, 0};
    y = '{0, 0, 65536, 65536};
    foreach (pts[i]) send_request(pack_point(pts[i][0], pts[i][1], x, y));
    // all corners at one spot: zero determinant
    x = '{0, 0, 0, 0}; y = '{0, 0, 0, 0};
    send_request(pack_point(16'd0, 16'd0, x, y));
    // collinear corners
    x = '{0, 65536, 131072, 196608}; y = '{0, 65536, 131072, 196608};
    send_request(pack_point(16'h1000, 16'hF000, x, y));
    // coordinate extremes: saturated Jacobian entries
    x = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    y = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_request(pack_point(16'd0, 16'd0, x, y));
    send_request(pack_point(16'h4000, 16'hC000, x, y));
    y = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    send_request(pack_point(16'h8000, 16'h8000, x, y));
    // one-LSB element: tiny determinant, saturated derivatives
    x = '{0, 1, 1, 0}; y = '{0, 0, 1, 1};
    send_request(pack_point(16'd0, 16'd0, x, y));
    x = '{0, 2, 2, 0}; y = '{0, 0, 2, 2};
    send_request(pack_point(16'h4000, 16'h4000, x, y));
    // clockwise unit square: negative determinant
    x = '{0, 0, 65536, 65536}; y = '{0, 65536, 65536, 0};
    send_request(pack_point(16'h2000, 16'h1000, x, y));
    // skewed quad
    x = '{-65536, 98304, 131072, -32768}; y = '{-32768, -65536, 98304, 65536};
    send_request(pack_point(16'hE000, 16'h3000, x, y));
  endtask

  // Result side: random stalls, plus one long hold-off to back up the pipe.
  // The hold-off lands well inside a run of requests so the pipe fills.
  initial begin : result_side
    int           stall;
    bit           hs, held;
    logic [319:0] d;
    logic [1:0]   u;
    held = 0;
    results_seen = 0;
    @(posedge clk iff rst_n);
    forever begin
      stall = (results_seen % 80 < 20) ? 0 : $urandom_range(0, 4);
      if (!held && results_seen == 260) begin
        stall = 300;
        held  = 1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        hs = out_tvalid;
        d  = out_tdata;
        u  = out_tuser;
        @(posedge clk);
      end while (!hs);
      sb.check_result(d, u);
      results_seen++;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_mode = 0;
    send_directed();
    send_random(90);
    burst_mode = 1;
    write_tolerance(63'd0);
    send_directed();
    send_random(90);
    burst_mode = 0;
    write_tolerance(63'h0000_0001_0000_0000);   // |det| of 1.0
    send_random(100);
    burst_mode = 1;
    write_tolerance(63'h7FFF_FFFF_FFFF_FFFF);   // everything singular
    send_random(40);
    burst_mode = 0;
    write_tolerance({$urandom_range(0, 1) ? 31'($urandom) : 31'd0, 32'($urandom)});
    send_random(100);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- q4_jacobian_global_derivs.f -----
sv/q4jd_pkg.sv
sv/q4jd_jac.sv
sv/q4jd_det.sv
sv/q4jd_div.sv
sv/q4_jacobian_global_derivs.sv
test/tb_q4_jacobian_global_derivs.sv
